@@ hw/rtl/sfbd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfbd_pkg
// Shared types and constants of the status frame button decoder: frame
// layout, button bit positions, register indexes and reset values.
// ----------------------------------------------------------------------------
package sfbd_pkg;

   // frame layout
   localparam int FRAME_BYTES      = 13;
   localparam int NUM_SENSORS      = 4;
   localparam int PAYLOAD_BYTES    = FRAME_BYTES - 1;
   localparam int BUTTON_WORD_POS  = 2 * NUM_SENSORS;
   localparam int BATTERY_WORD_POS = BUTTON_WORD_POS + 2;
   localparam int BYTE_COUNT_W     = 4;
   localparam logic [BYTE_COUNT_W-1:0] BYTE_COUNT_MAX = 4'd15;
   localparam logic [7:0]              CHECKSUM_GOOD  = 8'hFF;

   // battery conversion
   localparam int BATTERY_COUNT_W = 10;
   localparam int BATTERY_SHIFT   = 10;
   localparam int RECHARGE_BIT    = 15;

   // button bits
   localparam int BTN_ENTER_BIT  = 0;
   localparam int BTN_LEFT_BIT   = 1;
   localparam int BTN_RIGHT_BIT  = 2;
   localparam int BTN_ESCAPE_BIT = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_RELOAD  = 3'd0,
      CSR_LEFT_THRESHOLD   = 3'd1,
      CSR_RIGHT_THRESHOLD  = 3'd2,
      CSR_ESCAPE_THRESHOLD = 3'd3,
      CSR_ENTER_THRESHOLD  = 3'd4,
      CSR_ENTER_OFFSET     = 3'd5,
      CSR_BATTERY_SCALE    = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [7:0]  DEBOUNCE_RELOAD_RESET  = 8'd25;
   localparam logic [15:0] LEFT_THRESHOLD_RESET   = 16'd60;
   localparam logic [15:0] RIGHT_THRESHOLD_RESET  = 16'd270;
   localparam logic [15:0] ESCAPE_THRESHOLD_RESET = 16'd720;
   localparam logic [15:0] ENTER_THRESHOLD_RESET  = 16'd1500;
   localparam logic [15:0] ENTER_OFFSET_RESET     = 16'd2047;
   localparam logic [15:0] BATTERY_SCALE_RESET    = 16'd14180;

   typedef struct packed {
      logic [7:0]  debounce_reload;
      logic [15:0] left_threshold;
      logic [15:0] right_threshold;
      logic [15:0] escape_threshold;
      logic [15:0] enter_threshold;
      logic [15:0] enter_offset;
      logic [15:0] battery_scale;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic        frame_good;
      logic [3:0]  buttons;
      logic [15:0] adc_zero;
      logic [15:0] adc_one;
      logic [15:0] adc_two;
      logic [15:0] adc_three;
      logic [15:0] battery_mv;
      logic        rechargeable;
      logic [31:0] good_frames;
      logic [31:0] bad_frames;
   } rsp_type;

   // one finished frame as handed from front to back
   typedef struct packed {
      logic                          good;
      logic [PAYLOAD_BYTES-1:0][7:0] payload;
   } frame_rec_type;

   // queue handshake between modules
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

@@ hw/rtl/status_frame_button_decoder_top.sv @@
// ----------------------------------------------------------------------------
// status_frame_button_decoder_top
// Status frame receiver with button decode: configuration registers, byte
// collector, record queue and frame processor.
// ----------------------------------------------------------------------------
// The result of a frame is registered twice after the edge that accepts its final
// byte: the queue registers the record, then the back registers the result.
// Throughput: one byte per cycle; a frame result per cycle from the back while the receiver does not stall.
// The front stalls only while the record queue is full.
// Synchronous reset clears counters, held readings and button state and
// loads the register reset values; no clearing pass is needed.
module status_frame_button_decoder_top
   import sfbd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_ctrl_type   queue_ctrl;
   queue_status_type queue_status;
   frame_rec_type    push_rec;
   frame_rec_type    pop_rec;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_RELOAD:  cfg_in.debounce_reload  = csr_wdata[7:0];
            CSR_LEFT_THRESHOLD:   cfg_in.left_threshold   = csr_wdata;
            CSR_RIGHT_THRESHOLD:  cfg_in.right_threshold  = csr_wdata;
            CSR_ESCAPE_THRESHOLD: cfg_in.escape_threshold = csr_wdata;
            CSR_ENTER_THRESHOLD:  cfg_in.enter_threshold  = csr_wdata;
            CSR_ENTER_OFFSET:     cfg_in.enter_offset     = csr_wdata;
            CSR_BATTERY_SCALE:    cfg_in.battery_scale    = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_reload  <= DEBOUNCE_RELOAD_RESET;
         cfg_ff.left_threshold   <= LEFT_THRESHOLD_RESET;
         cfg_ff.right_threshold  <= RIGHT_THRESHOLD_RESET;
         cfg_ff.escape_threshold <= ESCAPE_THRESHOLD_RESET;
         cfg_ff.enter_threshold  <= ENTER_THRESHOLD_RESET;
         cfg_ff.enter_offset     <= ENTER_OFFSET_RESET;
         cfg_ff.battery_scale    <= BATTERY_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // byte collector
   sfbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_status.full),
      .queue_push (queue_ctrl.push),
      .queue_rec  (push_rec)
   );

   // record queue
   sfbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (queue_ctrl),
      .push_rec (push_rec),
      .status   (queue_status),
      .pop_rec  (pop_rec)
   );

   // frame processor
   sfbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_not_empty (queue_status.not_empty),
      .rec             (pop_rec),
      .queue_pop       (queue_ctrl.pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

@@ hw/rtl/sfbd_front.sv @@
// ----------------------------------------------------------------------------
// sfbd_front
// Byte collector: stores payload bytes, keeps length and checksum, and
// pushes one frame record into the queue on each marked final byte.
// ----------------------------------------------------------------------------
module sfbd_front
   import sfbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   input  logic          queue_full,
   output logic          queue_push,
   output frame_rec_type queue_rec
);

   logic [BYTE_COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]              sum_ff, sum_in;
   logic [7:0]              pending_ff [PAYLOAD_BYTES];
   logic                    accept;
   logic [7:0]              sum_next;

   // stall while the queue cannot take a record
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign sum_next  = sum_ff + req_data.rx_byte;

   // length and checksum tracking
   always_comb begin
      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      if (accept) begin
         if (req_data.frame_last) begin
            byte_count_in = '0;
            sum_in        = '0;
         end else begin
            sum_in = sum_next;
            if (byte_count_ff != BYTE_COUNT_MAX) begin
               byte_count_in = byte_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         sum_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
      end
   end

   // payload byte store
   always_ff @(posedge clock) begin
      if (accept && (byte_count_ff < BYTE_COUNT_W'(PAYLOAD_BYTES))) begin
         pending_ff[byte_count_ff] <= req_data.rx_byte;
      end
   end

   // frame record toward the back
   assign queue_push = accept && req_data.frame_last;

   always_comb begin
      queue_rec.good = (byte_count_ff == BYTE_COUNT_W'(PAYLOAD_BYTES)) &&
                       (sum_next == CHECKSUM_GOOD);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         queue_rec.payload[i] = pending_ff[i];
      end
   end

endmodule

@@ hw/rtl/sfbd_queue.sv @@
// ----------------------------------------------------------------------------
// sfbd_queue
// Short first-in first-out queue of frame records between front and back.
// ----------------------------------------------------------------------------
module sfbd_queue
   import sfbd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctrl_type   ctrl,
   input  frame_rec_type    push_rec,
   output queue_status_type status,
   output frame_rec_type    pop_rec
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_rec_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign pop_rec          = entry_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !ctrl.push || ctrl.pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> status.not_empty)
      else $error("queue pop while empty");

endmodule

@@ hw/rtl/sfbd_back.sv @@
// ----------------------------------------------------------------------------
// sfbd_back
// Frame processor: takes frame records, updates held readings and counters,
// runs the button ladder and debounce, and registers the request result.
// ----------------------------------------------------------------------------
module sfbd_back
   import sfbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          queue_not_empty,
   input  frame_rec_type rec,
   output logic          queue_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   logic [15:0] held_adc_ff [NUM_SENSORS];
   logic [15:0] held_adc_in [NUM_SENSORS];
   logic [15:0] held_battery_ff, held_battery_in;
   logic [15:0] last_word_ff, last_word_in;
   logic [3:0]  candidate_ff, candidate_in;
   logic [7:0]  debounce_ff, debounce_in;
   logic [3:0]  stable_ff, stable_in;
   logic [31:0] good_count_ff, good_count_in;
   logic [31:0] bad_count_ff, bad_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] button_word;
   logic [15:0] ladder_word;
   logic [3:0]  pattern;
   logic [BATTERY_COUNT_W+15:0] battery_product;

   // take a record when the output register is free or being drained
   assign queue_pop = queue_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign button_word = {rec.payload[BUTTON_WORD_POS + 1], rec.payload[BUTTON_WORD_POS]};

   // frame bookkeeping and button decode
   always_comb begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         held_adc_in[i] = held_adc_ff[i];
      end
      held_battery_in = held_battery_ff;
      last_word_in    = last_word_ff;
      candidate_in    = candidate_ff;
      debounce_in     = debounce_ff;
      stable_in       = stable_ff;
      good_count_in   = good_count_ff;
      bad_count_in    = bad_count_ff;
      pattern         = '0;
      ladder_word     = button_word;
      if (queue_pop) begin
         if (rec.good) begin
            good_count_in = good_count_ff + 1'b1;
            for (int i = 0; i < NUM_SENSORS; i++) begin
               held_adc_in[i] = {rec.payload[2*i + 1], rec.payload[2*i]};
            end
            held_battery_in = {rec.payload[BATTERY_WORD_POS + 1],
                               rec.payload[BATTERY_WORD_POS]};
            if ((button_word > cfg.left_threshold) || (stable_ff != '0)) begin
               if (button_word != last_word_ff) begin
                  // noisy word: only remembered
                  last_word_in = button_word;
               end else begin
                  // threshold ladder with enter chording
                  if (button_word > cfg.enter_threshold) begin
                     pattern[BTN_ENTER_BIT] = 1'b1;
                     ladder_word = button_word - cfg.enter_offset;
                  end
                  if (ladder_word > cfg.escape_threshold) begin
                     pattern[BTN_ESCAPE_BIT] = 1'b1;
                  end else if (ladder_word > cfg.right_threshold) begin
                     pattern[BTN_RIGHT_BIT] = 1'b1;
                  end else if (ladder_word > cfg.left_threshold) begin
                     pattern[BTN_LEFT_BIT] = 1'b1;
                  end
                  // debounce
                  if (pattern != candidate_ff) begin
                     debounce_in  = cfg.debounce_reload;
                     candidate_in = pattern;
                  end else if (debounce_ff != '0) begin
                     debounce_in = debounce_ff - 1'b1;
                  end else begin
                     stable_in = candidate_ff;
                  end
               end
            end
         end else begin
            bad_count_in = bad_count_ff + 1'b1;
         end
      end
   end

   // result assembly
   assign battery_product = held_battery_in[BATTERY_COUNT_W-1:0] * cfg.battery_scale;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (queue_pop) begin
         rsp_valid_in        = 1'b1;
         rsp_in.frame_good   = rec.good;
         rsp_in.buttons      = stable_in;
         rsp_in.adc_zero     = held_adc_in[0];
         rsp_in.adc_one      = held_adc_in[1];
         rsp_in.adc_two      = held_adc_in[2];
         rsp_in.adc_three    = held_adc_in[3];
         rsp_in.battery_mv   = battery_product[BATTERY_SHIFT +: 16];
         rsp_in.rechargeable = held_battery_in[RECHARGE_BIT];
         rsp_in.good_frames  = good_count_in;
         rsp_in.bad_frames   = bad_count_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            held_adc_ff[i] <= '0;
         end
         held_battery_ff <= '0;
         last_word_ff    <= '0;
         candidate_ff    <= '0;
         debounce_ff     <= DEBOUNCE_RELOAD_RESET;
         stable_ff       <= '0;
         good_count_ff   <= '0;
         bad_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            held_adc_ff[i] <= held_adc_in[i];
         end
         held_battery_ff <= held_battery_in;
         last_word_ff    <= last_word_in;
         candidate_ff    <= candidate_in;
         debounce_ff     <= debounce_in;
         stable_ff       <= stable_in;
         good_count_ff   <= good_count_in;
         bad_count_ff    <= bad_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_stable_on_good: assert property (@(posedge clock) disable iff (reset)
      !$stable(stable_ff) |-> $past(reset) || $past(queue_pop && rec.good))
      else $error("stable buttons changed without a good frame");

   a_one_count_per_frame: assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> 32'(good_count_ff + bad_count_ff) ==
                    32'($past(good_count_ff + bad_count_ff) + 32'd1))
      else $error("frame counters out of step");

   a_result_after_pop: assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> rsp_valid_ff && (rsp_ff.buttons == stable_ff))
      else $error("result not registered after frame was taken");

   a_counters_idle: assert property (@(posedge clock) disable iff (reset)
      !queue_pop |=> $stable(good_count_ff) && $stable(bad_count_ff))
      else $error("counters moved without a frame");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the status frame button decoder. Sends status frames
// byte by byte: well-formed frames with repeated button words so the debounce
// can settle, plus noisy words, bad checksums and short and overlong frames.
// It goes through several register settings. A scoreboard predicts each frame
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb
   import sfbd_pkg::*;
();

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 5;
   localparam int MAX_GAP      = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int NUM_PHASES   = 8;
   localparam int MAX_FRAME    = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   // --------------------------------------------------------------------------
   // frame scoreboard: predicts one status result per final byte
   // --------------------------------------------------------------------------
   class status_frame_scoreboard;
      logic [7:0]  debounce_reload;
      logic [15:0] left_thr, right_thr, escape_thr, enter_thr, enter_off, battery_scale;
      logic [3:0]  byte_cnt;
      logic [7:0]  sum;
      logic [7:0]  payload [PAYLOAD_BYTES];
      logic [15:0] adc [NUM_SENSORS];
      logic [15:0] battery, last_word;
      logic [3:0]  candidate, stable;
      logic [7:0]  debounce_left;
      logic [31:0] good_cnt, bad_cnt;
      rsp_type     pending_status[$];
      int          mismatches;

      function new();
         debounce_reload = DEBOUNCE_RELOAD_RESET;
         left_thr        = LEFT_THRESHOLD_RESET;
         right_thr       = RIGHT_THRESHOLD_RESET;
         escape_thr      = ESCAPE_THRESHOLD_RESET;
         enter_thr       = ENTER_THRESHOLD_RESET;
         enter_off       = ENTER_OFFSET_RESET;
         battery_scale   = BATTERY_SCALE_RESET;
         byte_cnt        = '0;
         sum             = '0;
         foreach (payload[i]) payload[i] = '0;
         foreach (adc[i]) adc[i] = '0;
         battery         = '0;
         last_word       = '0;
         candidate       = '0;
         stable          = '0;
         debounce_left   = DEBOUNCE_RELOAD_RESET;
         good_cnt        = '0;
         bad_cnt         = '0;
         mismatches      = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [15:0] v);
         case (idx)
            CSR_DEBOUNCE_RELOAD:  debounce_reload = v[7:0];
            CSR_LEFT_THRESHOLD:   left_thr = v;
            CSR_RIGHT_THRESHOLD:  right_thr = v;
            CSR_ESCAPE_THRESHOLD: escape_thr = v;
            CSR_ENTER_THRESHOLD:  enter_thr = v;
            CSR_ENTER_OFFSET:     enter_off = v;
            CSR_BATTERY_SCALE:    battery_scale = v;
            default: ;
         endcase
      endfunction

      function logic [15:0] word_at(int pos);
         return {payload[pos + 1], payload[pos]};
      endfunction

      // gate, noise filter, threshold ladder with enter chord, debounce
      function void decode_buttons(logic [15:0] word);
         logic [3:0] pattern;
         pattern = '0;
         if (!(word > left_thr || stable != 0)) return;
         if (word != last_word) begin
            last_word = word;
            return;
         end
         if (word > enter_thr) begin
            pattern[BTN_ENTER_BIT] = 1'b1;
            word = word - enter_off;
         end
         if (word > escape_thr) pattern[BTN_ESCAPE_BIT] = 1'b1;
         else if (word > right_thr) pattern[BTN_RIGHT_BIT] = 1'b1;
         else if (word > left_thr) pattern[BTN_LEFT_BIT] = 1'b1;
         if (pattern != candidate) begin
            debounce_left = debounce_reload;
            candidate = pattern;
         end else if (debounce_left > 0) begin
            debounce_left--;
         end else begin
            stable = candidate;
         end
      endfunction

      function void take_byte(req_type r);
         rsp_type     s;
         logic        good;
         logic [25:0] product;
         if (byte_cnt < PAYLOAD_BYTES) payload[byte_cnt] = r.rx_byte;
         sum = sum + r.rx_byte;
         if (!r.frame_last) begin
            if (byte_cnt != BYTE_COUNT_MAX) byte_cnt++;
            return;
         end
         good = (byte_cnt == PAYLOAD_BYTES) && (sum == CHECKSUM_GOOD);
         byte_cnt = '0;
         sum = '0;
         if (good) begin
            good_cnt++;
            for (int i = 0; i < NUM_SENSORS; i++) adc[i] = word_at(2 * i);
            battery = word_at(BATTERY_WORD_POS);
            decode_buttons(word_at(BUTTON_WORD_POS));
         end else begin
            bad_cnt++;
         end
         product = battery[BATTERY_COUNT_W-1:0] * battery_scale;
         s.frame_good   = good;
         s.buttons      = stable;
         s.adc_zero     = adc[0];
         s.adc_one      = adc[1];
         s.adc_two      = adc[2];
         s.adc_three    = adc[3];
         s.battery_mv   = product[BATTERY_SHIFT +: 16];
         s.rechargeable = battery[RECHARGE_BIT];
         s.good_frames  = good_cnt;
         s.bad_frames   = bad_cnt;
         pending_status.push_back(s);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void match_status(rsp_type got);
         rsp_type want;
         if (pending_status.size() == 0) begin
            $display("%0t: status %h with no frame outstanding", $time, got);
            mismatches++;
            return;
         end
         want = pending_status.pop_front();
         check_field("frame_good", want.frame_good, got.frame_good);
         check_field("buttons", want.buttons, got.buttons);
         check_field("adc_zero", want.adc_zero, got.adc_zero);
         check_field("adc_one", want.adc_one, got.adc_one);
         check_field("adc_two", want.adc_two, got.adc_two);
         check_field("adc_three", want.adc_three, got.adc_three);
         check_field("battery_mv", want.battery_mv, got.battery_mv);
         check_field("rechargeable", want.rechargeable, got.rechargeable);
         check_field("good_frames", want.good_frames, got.good_frames);
         check_field("bad_frames", want.bad_frames, got.bad_frames);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   status_frame_scoreboard frames;
   bit idle_on;
   bit hold_rsp;
   int quiet_cycles;

   status_frame_button_decoder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // request and status monitors
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) frames.take_byte(req_data);
      if (!reset && rsp_valid && !rsp_stall) frames.match_status(rsp_data);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // status receiver: random stalls, one long hold-off on request
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_rsp) begin
            gap = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one byte request; valid stays high after acceptance until the next call
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_type r;
      int      gap;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.rx_byte    = b;
      r.frame_last = last;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // frame with every payload byte equal and a correct checksum
   task automatic send_filled(input logic [7:0] fill);
      logic [7:0] total;
      total = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         send_byte(fill, 1'b0);
         total = total + fill;
      end
      send_byte(CHECKSUM_GOOD - total, 1'b1);
   endtask

   // random frame around a button word; len other than FRAME_BYTES is a bad length
   task automatic send_status_frame(input logic [15:0] button_word, input int len,
                                    input bit corrupt);
      logic [7:0] data [MAX_FRAME];
      logic [7:0] total;
      foreach (data[i]) data[i] = 8'($urandom);
      data[BUTTON_WORD_POS]     = button_word[7:0];
      data[BUTTON_WORD_POS + 1] = button_word[15:8];
      total = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) total = total + data[i];
      data[PAYLOAD_BYTES] = CHECKSUM_GOOD - total;
      if (corrupt) data[PAYLOAD_BYTES] = data[PAYLOAD_BYTES] + 8'($urandom_range(1, 255));
      for (int i = 0; i < len; i++) send_byte(data[i], i == len - 1);
   endtask

   // button words placed around the current thresholds
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return frames.left_thr;
         2: return frames.left_thr + 16'd1;
         3: return frames.right_thr + 16'd1;
         4: return frames.escape_thr + 16'd1;
         5: return frames.enter_thr + 16'd1;
         6: return frames.enter_off + frames.left_thr + 16'd1;
         7: return frames.enter_off + frames.right_thr + 16'd1;
         8: return frames.enter_off + frames.escape_thr + 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // drop valid and let every outstanding status come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      frames.set_register(idx, v);
   endtask

   // register setting of each phase; block is idle here
   task automatic set_phase(input int p);
      logic [15:0] left, right, escape;
      case (p)
         0: write_csr(CSR_UNUSED_INDEX, 16'($urandom));
         1: begin
            write_csr(CSR_DEBOUNCE_RELOAD, 16'd0);
            write_csr(CSR_LEFT_THRESHOLD, 16'd0);
            write_csr(CSR_RIGHT_THRESHOLD, 16'd100);
            write_csr(CSR_ESCAPE_THRESHOLD, 16'd400);
            write_csr(CSR_ENTER_THRESHOLD, 16'hFFFF);
            write_csr(CSR_ENTER_OFFSET, 16'd0);
            write_csr(CSR_BATTERY_SCALE, 16'hFFFF);
         end
         2: begin
            write_csr(CSR_DEBOUNCE_RELOAD, 16'd255);
            write_csr(CSR_LEFT_THRESHOLD, 16'hFFFF);
            write_csr(CSR_RIGHT_THRESHOLD, 16'hFFFF);
            write_csr(CSR_ESCAPE_THRESHOLD, 16'hFFFF);
            write_csr(CSR_ENTER_THRESHOLD, 16'hFFFF);
            write_csr(CSR_ENTER_OFFSET, 16'hFFFF);
            write_csr(CSR_BATTERY_SCALE, 16'd0);
         end
         default: begin
            left   = 16'($urandom_range(0, 300));
            right  = left + 16'($urandom_range(1, 400));
            escape = right + 16'($urandom_range(1, 800));
            write_csr(CSR_DEBOUNCE_RELOAD, 16'($urandom_range(0, 3)));
            write_csr(CSR_LEFT_THRESHOLD, left);
            write_csr(CSR_RIGHT_THRESHOLD, right);
            write_csr(CSR_ESCAPE_THRESHOLD, escape);
            write_csr(CSR_ENTER_THRESHOLD, escape + 16'($urandom_range(1, 3000)));
            write_csr(CSR_ENTER_OFFSET, 16'($urandom));
            write_csr(CSR_BATTERY_SCALE, 16'($urandom));
         end
      endcase
      csr_wr_en <= 1'b0;
   endtask

   // runs of repeated button words, with noise and broken frames mixed in
   task automatic run_phase(input int n_frames, input bit pause_midway);
      logic [15:0] word;
      int          run;
      run = 0;
      for (int f = 0; f < n_frames; f++) begin
         if (run == 0) begin
            word = pick_word();
            run  = $urandom_range(1, 8);
         end
         run--;
         if (pause_midway && f == n_frames / 2) wait_drained();
         case ($urandom_range(0, 9))
            0: send_status_frame(pick_word(), FRAME_BYTES, 1'b0);
            1: send_status_frame(word, FRAME_BYTES, 1'b1);
            2: send_status_frame(word, $urandom_range(1, FRAME_BYTES - 1), 1'b0);
            3: send_status_frame(word, $urandom_range(FRAME_BYTES + 1, MAX_FRAME), 1'b0);
            default: send_status_frame(word, FRAME_BYTES, 1'b0);
         endcase
      end
   endtask

   // main sequence
   initial begin
      frames    = new();
      idle_on   = 1'b1;
      hold_rsp  = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: all-ones payload frame, lone final byte, all-zero payload frame
      send_filled(8'hFF);
      send_byte(8'h00, 1'b1);
      send_filled(8'h00);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         set_phase(p);
         idle_on = (p != 3);
         if (p == 4) hold_rsp = 1'b1;
         run_phase($urandom_range(9, 11), p == 5);
      end

      wait_drained();
      if (frames.mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
